/* hdl/xpds_pkg.sv */
package xpds_pkg;

	localparam int WORD_BITS  = 64;
	localparam int MAX_WORDS  = 1024;
	localparam int POP_W      = $clog2(WORD_BITS + 1);
	localparam int WCNT_W     = $clog2(MAX_WORDS + 1);
	localparam int SUM_W      = $clog2(MAX_WORDS * WORD_BITS + 1);
	localparam int DOT_W      = 18;
	localparam int CALC_W     = SUM_W + 2;
	localparam int SCNT_W     = $clog2(WORD_BITS);
	localparam int DOT_MAX    = 65536;
	localparam int DOT_MIN    = -65536;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic signed [DOT_W-1:0] dot_t;

	typedef enum logic {
		REG_OUTPUT_MODE = 1'b0,
		REG_UNUSED      = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_DOT  = 1'b0,
		KIND_SIGN = 1'b1
	} kind_t;

endpackage

/* hdl/xpds_in_if.sv */
interface xpds_in_if;
	import xpds_pkg::*;

	logic  valid;
	logic  ready;
	word_t a_word;
	word_t b_word;
	logic  last_word;

	modport source (output valid, a_word, b_word, last_word, input ready);
	modport sink   (input valid, a_word, b_word, last_word, output ready);
endinterface

/* hdl/xpds_out_if.sv */
interface xpds_out_if;
	import xpds_pkg::*;

	logic  valid;
	logic  ready;
	dot_t  dot_value;
	word_t sign_word;
	logic  result_kind;
	logic  length_error;

	modport source (output valid, dot_value, sign_word, result_kind, length_error, input ready);
	modport sink   (input valid, dot_value, sign_word, result_kind, length_error, output ready);
endinterface

/* hdl/xpds_popcount.sv */
module xpds_popcount (
	input  xpds_pkg::word_t             vec,
	output logic [xpds_pkg::POP_W-1:0]  count
);
	import xpds_pkg::*;

	logic [3:0] nib [WORD_BITS/4];
	logic [POP_W-1:0] grp [WORD_BITS/16];

	always_comb begin
		for (int i = 0; i < WORD_BITS/4; i++) begin
			nib[i] = 4'(vec[4*i]) + 4'(vec[4*i+1]) + 4'(vec[4*i+2]) + 4'(vec[4*i+3]);
		end
		for (int g = 0; g < WORD_BITS/16; g++) begin
			grp[g] = POP_W'(nib[4*g]) + POP_W'(nib[4*g+1])
				+ POP_W'(nib[4*g+2]) + POP_W'(nib[4*g+3]);
		end
		count = '0;
		for (int g = 0; g < WORD_BITS/16; g++) begin
			count = count + grp[g];
		end
	end

endmodule

/* hdl/xnor_popcount_dot_sign_pack.sv */
// Binary dot product engine. Each item is a pair of 64-bit packed binary words
// (bit 1 = +1, bit 0 = -1); the item with last_word set closes a vector. One
// item is accepted per clock while no result waits at the output: a 64-bit
// popcount of a^b plus the accumulator add is done in a single pass between the
// input register and the result register, which offers the result. In value
// mode (output_mode 0) each vector yields its dot product words*64 - 2*mismatches;
// in pack mode (output_mode 1) the sign bits of 64 dot products are packed into
// one sign_word, bit i for the i-th dot. Words beyond 1024 per vector are dropped
// and flagged through length_error. Write output_mode only while no item is in
// flight; the write also clears any partly packed sign word.
module xnor_popcount_dot_sign_pack (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [xpds_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [xpds_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [xpds_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	xpds_in_if.sink                          in_ch,
	xpds_out_if.source                       out_ch
);
	import xpds_pkg::*;

	logic             mode_q;
	logic             valid_s1;
	word_t            a_s1;
	word_t            b_s1;
	logic             last_s1;
	logic [SUM_W-1:0] sum_q;
	logic [WCNT_W-1:0] wcnt_q;
	word_t            shift_q;
	logic [SCNT_W-1:0] scnt_q;
	logic             ovf_q;
	logic             out_valid_q;
	dot_t             dot_q;
	word_t            sword_q;
	logic             kind_q;
	logic             err_q;

	logic [POP_W-1:0]  pop;
	logic              adv;
	logic              fire;
	logic              cnt_ok;
	logic [SUM_W-1:0]  sum_n;
	logic [WCNT_W-1:0] wcnt_n;
	logic              ovf_n;
	logic signed [CALC_W-1:0] dot_full;
	dot_t              dot_clamp;
	logic              neg;
	word_t             shift_n;
	logic [SCNT_W-1:0] scnt_n;
	logic              emit;
	logic              cfg_wr;

	xpds_popcount u_pop (
		.vec   (a_s1 ^ b_s1),
		.count (pop)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (reg_idx_t'(paddr[CFG_ADDR_W-1]) == REG_OUTPUT_MODE);
	assign prdata = (reg_idx_t'(paddr[CFG_ADDR_W-1]) == REG_OUTPUT_MODE)
		? CFG_DATA_W'(mode_q) : '0;

	assign adv         = !out_valid_q || out_ch.ready;
	assign fire        = valid_s1 && adv;
	assign in_ch.ready = !valid_s1 || adv;

	always_comb begin
		cnt_ok   = wcnt_q < WCNT_W'(MAX_WORDS);
		sum_n    = cnt_ok ? sum_q + SUM_W'(pop) : sum_q;
		wcnt_n   = cnt_ok ? wcnt_q + 1'b1 : wcnt_q;
		ovf_n    = ovf_q || !cnt_ok;
		dot_full = signed'(CALC_W'(wcnt_n) << $clog2(WORD_BITS))
			- signed'(CALC_W'(sum_n) << 1);
		neg      = dot_full[CALC_W-1];
		if (dot_full < CALC_W'(DOT_MIN)) begin
			dot_clamp = DOT_W'(DOT_MIN);
		end else if (dot_full > CALC_W'(DOT_MAX)) begin
			dot_clamp = DOT_W'(DOT_MAX);
		end else begin
			dot_clamp = DOT_W'(dot_full);
		end
		shift_n = shift_q | (word_t'(neg) << scnt_q);
		scnt_n  = scnt_q + 1'b1;
		emit    = fire && last_s1 && (!mode_q || (scnt_n == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			valid_s1    <= 1'b0;
			sum_q       <= '0;
			wcnt_q      <= '0;
			shift_q     <= '0;
			scnt_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				mode_q  <= pwdata[0];
				shift_q <= '0;
				scnt_q  <= '0;
			end
			if (fire) begin
				if (!last_s1) begin
					sum_q  <= sum_n;
					wcnt_q <= wcnt_n;
					ovf_q  <= ovf_n;
				end else begin
					sum_q  <= '0;
					wcnt_q <= '0;
					if (!mode_q) begin
						ovf_q <= 1'b0;
					end else begin
						scnt_q <= scnt_n;
						if (scnt_n == '0) begin
							shift_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							shift_q <= shift_n;
							ovf_q   <= ovf_n;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			a_s1    <= in_ch.a_word;
			b_s1    <= in_ch.b_word;
			last_s1 <= in_ch.last_word;
		end
		if (emit) begin
			err_q <= ovf_n;
			if (!mode_q) begin
				dot_q   <= dot_clamp;
				sword_q <= '0;
				kind_q  <= KIND_DOT;
			end else begin
				dot_q   <= '0;
				sword_q <= shift_n;
				kind_q  <= KIND_SIGN;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.dot_value    = dot_q;
	assign out_ch.sign_word    = sword_q;
	assign out_ch.result_kind  = kind_q;
	assign out_ch.length_error = err_q;

endmodule
